// ===== design/assert_macros.svh =====
// Assertion macros shared by the grid restriction RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define G3D_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("g3d_rfw: property violated");
`define G3D_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("g3d_rfw: forbidden condition seen");
`else
`define G3D_ASSERT(name, prop)
`define G3D_ASSERT_NEVER(name, expr)
`endif
`endif

// ===== design/g3d_rfw_pkg.sv =====
`timescale 1ns / 1ps

package g3d_rfw_pkg;

  localparam int unsigned SizeW      = 5;   // size register width
  localparam int unsigned PosW       = 5;   // position field width
  localparam int unsigned CoordW     = 7;   // fine coordinate, covers 2*31+2
  localparam int unsigned TapCntW    = 6;   // 4x4x4 taps
  localparam int unsigned WgtW       = 5;   // tap weights 1, 3, 9, 27
  localparam int unsigned RoundShift = 9;   // divide by 512
  localparam int unsigned PaddrW     = 4;
  localparam int unsigned PdataW     = 32;

  localparam logic [SizeW-1:0] SizeReset = 5'd16;

  localparam logic [1:0] RegSizeX = 2'd0;
  localparam logic [1:0] RegSizeY = 2'd1;
  localparam logic [1:0] RegSizeZ = 2'd2;

  typedef enum logic [0:0] {
    OpWrite   = 1'b0,
    OpCompute = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    SIdle,
    SRead,
    SFinish
  } state_e;

  typedef struct packed {
    logic [SizeW-1:0] nx;
    logic [SizeW-1:0] ny;
    logic [SizeW-1:0] nz;
  } size_t;

  typedef struct packed {
    logic            clear;
    logic            issue;
    logic [WgtW-1:0] weight;
  } mac_ctl_t;

  typedef struct packed {
    logic rd_pend;
    logic prod_pend;
  } mac_sts_t;

  // Fine neighbor index for coarse cell c on an axis of n coarse cells.
  function automatic logic [CoordW-1:0] nbr_idx(input logic [PosW-1:0]  c,
                                                input logic [SizeW-1:0] n,
                                                input logic [1:0]       sel);
    logic [CoordW-1:0] two_c;
    two_c = {1'b0, c, 1'b0};
    case (sel)
      2'd0: nbr_idx = (c != '0) ? two_c - CoordW'(1) : two_c;
      2'd1: nbr_idx = two_c;
      2'd2: nbr_idx = two_c + CoordW'(1);
      default: begin
        nbr_idx = (({1'b0, c} + 6'd1) < {1'b0, n}) ? two_c + CoordW'(2)
                                                   : two_c + CoordW'(1);
      end
    endcase
  endfunction

  // Product of the three 1D weights: 3 per axis for an inner tap, else 1.
  function automatic logic [WgtW-1:0] tap_weight(input logic [TapCntW-1:0] k);
    logic [1:0] inner;
    inner = 2'(k[1] ^ k[0]) + 2'(k[3] ^ k[2]) + 2'(k[5] ^ k[4]);
    case (inner)
      2'd0:    tap_weight = 5'd1;
      2'd1:    tap_weight = 5'd3;
      2'd2:    tap_weight = 5'd9;
      default: tap_weight = 5'd27;
    endcase
  endfunction

endpackage

// ===== design/g3d_rfw_if.sv =====
`timescale 1ns / 1ps

interface g3d_rfw_req_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
) ();
  logic                                   valid;
  logic                                   ready;
  g3d_rfw_pkg::opcode_e                   opcode;
  logic [g3d_rfw_pkg::PosW-1:0]           pos_x;
  logic [g3d_rfw_pkg::PosW-1:0]           pos_y;
  logic [g3d_rfw_pkg::PosW-1:0]           pos_z;
  logic signed [SAMPLE_WIDTH-1:0]         sample_value;

  modport source (
    output valid, opcode, pos_x, pos_y, pos_z, sample_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, pos_z, sample_value,
    output ready
  );
endinterface

interface g3d_rfw_rsp_if #(
  parameter int unsigned SAMPLE_WIDTH = 32
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] coarse_value;
  logic                           range_error;

  modport source (
    output valid, coarse_value, range_error,
    input  ready
  );
  modport sink (
    input  valid, coarse_value, range_error,
    output ready
  );
endinterface

// ===== design/grid3d_restrict_full_weighting.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// req_i     in   valid/ready        opcode, pos_x, pos_y, pos_z, sample_value
// rsp_o     out  valid/ready        coarse_value, range_error
// apb       in   psel/penable/pwr   paddr, pwdata -> prdata (pready tied high)
//
// A write request writes the fine memory directly.
// A compute request is accepted, makes 64 reads of the single read port
// of the fine memory (one tap per cycle), lets the multiply/accumulate pipe
// drain, then loads the result into the output register.
// An out-of-range compute skips the reads and answers from the finish state.
// Reset (async, low) clears control only; the fine memory has no clear pass.
// A held result never blocks new write requests; a compute waits at its end
// until the output register frees up.
`include "assert_macros.svh"

module grid3d_restrict_full_weighting #(
  parameter int unsigned COARSE_MAX   = 16,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  g3d_rfw_req_if.sink                    req_i,
  g3d_rfw_rsp_if.source                  rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [g3d_rfw_pkg::PaddrW-1:0] paddr,
  input  logic [g3d_rfw_pkg::PdataW-1:0] pwdata,
  output logic [g3d_rfw_pkg::PdataW-1:0] prdata,
  output logic                           pready
);

  // fine grid per axis is 2*COARSE_MAX, address is {z, y, x}
  localparam int unsigned FineW = $clog2(2 * COARSE_MAX);
  localparam int unsigned AddrW = 3 * FineW;

  g3d_rfw_pkg::size_t    size;
  g3d_rfw_pkg::mac_ctl_t mac_ctl;
  g3d_rfw_pkg::mac_sts_t mac_sts;

  logic                    mem_we, mem_re;
  logic [AddrW-1:0]        mem_waddr, mem_raddr;
  logic [SAMPLE_WIDTH-1:0] mem_wdata, mem_rdata, mac_result;

  // size registers, clamped to 1..COARSE_MAX
  g3d_rfw_cfg #(
    .COARSE_MAX (COARSE_MAX)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  // request decode, tap sequencer and output register
  g3d_rfw_seq #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FINE_W       (FineW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .rsp_o        (rsp_o),
    .size_i       (size),
    .mac_sts_i    (mac_sts),
    .mac_result_i (mac_result),
    .mac_ctl_o    (mac_ctl),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr)
  );

  // fine grid storage, registered read
  g3d_rfw_mem #(
    .ADDR_W (AddrW),
    .DATA_W (SAMPLE_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // weight multiply, accumulate, round by 512
  g3d_rfw_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .rdata_i  (mem_rdata),
    .sts_o    (mac_sts),
    .result_o (mac_result)
  );

  // writes happen only in idle, reads only while sweeping taps
  `G3D_ASSERT_NEVER(a_no_rw_overlap, mem_we && mem_re)
  // every issued read shows up in the multiply stage in the next cycle
  `G3D_ASSERT(a_read_lands, mem_re |=> mac_sts.rd_pend)
  // a new request only enters with the accumulate pipe empty
  `G3D_ASSERT(a_accept_drained, (req_i.valid && req_i.ready) |-> !(mac_sts.rd_pend || mac_sts.prod_pend))

endmodule

// ===== design/g3d_rfw_cfg.sv =====
`timescale 1ns / 1ps

module g3d_rfw_cfg #(
  parameter int unsigned COARSE_MAX = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [g3d_rfw_pkg::PaddrW-1:0]     paddr,
  input  logic [g3d_rfw_pkg::PdataW-1:0]     pwdata,
  output logic [g3d_rfw_pkg::PdataW-1:0]     prdata,
  output logic                               pready,
  output g3d_rfw_pkg::size_t                 size_o
);

  localparam logic [g3d_rfw_pkg::CoordW-1:0] CmaxC = g3d_rfw_pkg::CoordW'(COARSE_MAX);

  logic [g3d_rfw_pkg::SizeW-1:0] sx_q, sy_q, sz_q;
  logic [1:0]                    reg_idx;
  logic                          wr_en;

  // 0 acts as 1, anything above the build maximum acts as the maximum
  function automatic logic [g3d_rfw_pkg::SizeW-1:0] eff_size(
    input logic [g3d_rfw_pkg::SizeW-1:0] raw);
    if (raw == '0) begin
      eff_size = g3d_rfw_pkg::SizeW'(1);
    end else if ({2'b00, raw} > CmaxC) begin
      eff_size = CmaxC[g3d_rfw_pkg::SizeW-1:0];
    end else begin
      eff_size = raw;
    end
  endfunction

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= g3d_rfw_pkg::SizeReset;
      sy_q <= g3d_rfw_pkg::SizeReset;
      sz_q <= g3d_rfw_pkg::SizeReset;
    end else if (wr_en) begin
      case (reg_idx)
        g3d_rfw_pkg::RegSizeX: sx_q <= pwdata[g3d_rfw_pkg::SizeW-1:0];
        g3d_rfw_pkg::RegSizeY: sy_q <= pwdata[g3d_rfw_pkg::SizeW-1:0];
        g3d_rfw_pkg::RegSizeZ: sz_q <= pwdata[g3d_rfw_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      g3d_rfw_pkg::RegSizeX: prdata = g3d_rfw_pkg::PdataW'(sx_q);
      g3d_rfw_pkg::RegSizeY: prdata = g3d_rfw_pkg::PdataW'(sy_q);
      g3d_rfw_pkg::RegSizeZ: prdata = g3d_rfw_pkg::PdataW'(sz_q);
      default:               prdata = '0;
    endcase
  end

  assign size_o.nx = eff_size(sx_q);
  assign size_o.ny = eff_size(sy_q);
  assign size_o.nz = eff_size(sz_q);

endmodule

// ===== design/g3d_rfw_mem.sv =====
`timescale 1ns / 1ps

module g3d_rfw_mem #(
  parameter int unsigned ADDR_W = 15,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] ram_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= ram_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/g3d_rfw_mac.sv =====
`timescale 1ns / 1ps

module g3d_rfw_mac #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  g3d_rfw_pkg::mac_ctl_t          ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] rdata_i,
  output g3d_rfw_pkg::mac_sts_t          sts_o,
  output logic [SAMPLE_WIDTH-1:0]        result_o
);

  localparam int unsigned WgtW  = g3d_rfw_pkg::WgtW;
  localparam int unsigned ProdW = SAMPLE_WIDTH + WgtW;
  localparam int unsigned AccW  = SAMPLE_WIDTH + 10;
  localparam int unsigned Shift = g3d_rfw_pkg::RoundShift;

  logic                    rd_vld_q, prod_vld_q;
  logic [WgtW-1:0]         wgt_q;
  logic signed [ProdW:0]   prod_full;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [AccW-1:0]         rounded;

  // weight travels alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctl_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wgt_q <= ctl_i.weight;
  end

  // weights are at most 27, so the product fits ProdW bits
  assign prod_full = rdata_i * $signed({1'b0, wgt_q});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[ProdW-1:0];
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // floor((sum + 256) / 512), low bits of the arithmetic shift
  assign rounded  = acc_q + AccW'(1 << (Shift - 1));
  assign result_o = rounded[Shift+SAMPLE_WIDTH-1:Shift];

  assign sts_o.rd_pend   = rd_vld_q;
  assign sts_o.prod_pend = prod_vld_q;

endmodule

// ===== design/g3d_rfw_seq.sv =====
`timescale 1ns / 1ps

module g3d_rfw_seq #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned FINE_W       = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  g3d_rfw_req_if.sink                 req_i,
  g3d_rfw_rsp_if.source               rsp_o,
  input  g3d_rfw_pkg::size_t          size_i,
  input  g3d_rfw_pkg::mac_sts_t       mac_sts_i,
  input  logic [SAMPLE_WIDTH-1:0]     mac_result_i,
  output g3d_rfw_pkg::mac_ctl_t       mac_ctl_o,
  output logic                        mem_we_o,
  output logic [3*FINE_W-1:0]         mem_waddr_o,
  output logic [SAMPLE_WIDTH-1:0]     mem_wdata_o,
  output logic                        mem_re_o,
  output logic [3*FINE_W-1:0]         mem_raddr_o
);

  localparam int unsigned CoordW = g3d_rfw_pkg::CoordW;

  g3d_rfw_pkg::state_e state_q, state_d;

  logic [g3d_rfw_pkg::TapCntW-1:0] cnt_q;
  logic [FINE_W-1:0]               ix_q [4];
  logic [FINE_W-1:0]               iy_q [4];
  logic [FINE_W-1:0]               iz_q [4];
  logic [CoordW-1:0]               nbr_x [4];
  logic [CoordW-1:0]               nbr_y [4];
  logic [CoordW-1:0]               nbr_z [4];
  logic                            err_q;
  logic                            rsp_valid_q, rsp_valid_d;
  logic [SAMPLE_WIDTH-1:0]         rsp_value_q;
  logic                            rsp_err_q;

  logic              accept, is_compute, in_bounds, range_err, finish_ok, load_rsp;
  logic [CoordW-1:0] wx, wy, wz;

  assign accept     = req_i.valid && req_i.ready;
  assign is_compute = (req_i.opcode == g3d_rfw_pkg::OpCompute);

  assign wx = CoordW'(req_i.pos_x);
  assign wy = CoordW'(req_i.pos_y);
  assign wz = CoordW'(req_i.pos_z);

  assign in_bounds = (wx < {1'b0, size_i.nx, 1'b0}) &&
                     (wy < {1'b0, size_i.ny, 1'b0}) &&
                     (wz < {1'b0, size_i.nz, 1'b0});
  assign range_err = (req_i.pos_x >= size_i.nx) || (req_i.pos_y >= size_i.ny) ||
                     (req_i.pos_z >= size_i.nz);

  // write path: in-bounds positions always fit FINE_W bits
  assign mem_we_o    = accept && !is_compute && in_bounds;
  assign mem_waddr_o = {wz[FINE_W-1:0], wy[FINE_W-1:0], wx[FINE_W-1:0]};
  assign mem_wdata_o = req_i.sample_value;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nbr_x[i] = g3d_rfw_pkg::nbr_idx(req_i.pos_x, size_i.nx, 2'(i));
      nbr_y[i] = g3d_rfw_pkg::nbr_idx(req_i.pos_y, size_i.ny, 2'(i));
      nbr_z[i] = g3d_rfw_pkg::nbr_idx(req_i.pos_z, size_i.nz, 2'(i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_compute) begin
      err_q <= range_err;
      for (int i = 0; i < 4; i++) begin
        ix_q[i] <= nbr_x[i][FINE_W-1:0];
        iy_q[i] <= nbr_y[i][FINE_W-1:0];
        iz_q[i] <= nbr_z[i][FINE_W-1:0];
      end
    end
  end

  assign finish_ok = !mac_sts_i.rd_pend && !mac_sts_i.prod_pend &&
                     (!rsp_valid_q || rsp_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      g3d_rfw_pkg::SIdle: begin
        if (accept && is_compute) begin
          state_d = range_err ? g3d_rfw_pkg::SFinish : g3d_rfw_pkg::SRead;
        end
      end
      g3d_rfw_pkg::SRead: begin
        if (cnt_q == '1) begin
          state_d = g3d_rfw_pkg::SFinish;
        end
      end
      g3d_rfw_pkg::SFinish: begin
        if (finish_ok) begin
          state_d = g3d_rfw_pkg::SIdle;
        end
      end
      default: state_d = g3d_rfw_pkg::SIdle;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready      = 1'b0;
    mem_re_o         = 1'b0;
    load_rsp         = 1'b0;
    mac_ctl_o.clear  = accept && is_compute;
    mac_ctl_o.issue  = 1'b0;
    mac_ctl_o.weight = g3d_rfw_pkg::tap_weight(cnt_q);
    case (state_q)
      g3d_rfw_pkg::SIdle:   req_i.ready = 1'b1;
      g3d_rfw_pkg::SRead: begin
        mem_re_o        = 1'b1;
        mac_ctl_o.issue = 1'b1;
      end
      g3d_rfw_pkg::SFinish: load_rsp = finish_ok;
      default: ;
    endcase
  end

  // tap order: x fastest, then y, then z
  assign mem_raddr_o = {iz_q[cnt_q[5:4]], iy_q[cnt_q[3:2]], ix_q[cnt_q[1:0]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= g3d_rfw_pkg::SIdle;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == g3d_rfw_pkg::SRead) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      rsp_value_q <= err_q ? '0 : mac_result_i;
      rsp_err_q   <= err_q;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.coarse_value = rsp_value_q;
  assign rsp_o.range_error  = rsp_err_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// One request as the stimulus sees it.
typedef struct {
  g3d_rfw_pkg::opcode_e                op;
  logic [g3d_rfw_pkg::PosW-1:0]        x;
  logic [g3d_rfw_pkg::PosW-1:0]        y;
  logic [g3d_rfw_pkg::PosW-1:0]        z;
  logic signed [31:0]                  sample;
} grid_req_t;

typedef struct {
  logic signed [31:0] value;
  logic               err;
} coarse_res_t;

class coarse_scoreboard;
  localparam int CoarseMax = 16;
  localparam int FineDim   = 2 * CoarseMax;
  localparam int FineCells = FineDim * FineDim * FineDim;

  logic [4:0]         size_reg[3];
  logic signed [31:0] fine_mem[FineCells];
  bit                 written[FineCells];
  coarse_res_t        coarse_q[$];
  int                 mismatches;
  int                 checked;

  function new();
    size_reg[0] = 5'd16;
    size_reg[1] = 5'd16;
    size_reg[2] = 5'd16;
    mismatches  = 0;
    checked     = 0;
  endfunction

  // 0 acts as 1, anything past the maximum as the maximum.
  function int eff_size(int axis);
    int r;
    r = size_reg[axis];
    if (r < 1) return 1;
    if (r > CoarseMax) return CoarseMax;
    return r;
  endfunction

  function int fine_index(int x, int y, int z);
    return (z * FineDim + y) * FineDim + x;
  endfunction

  // Fine taps of coarse cell c on an axis of n cells, outer taps clamped.
  function void axis_taps(input int c, input int n, output int t[4]);
    t[0] = (c > 0) ? 2 * c - 1 : 2 * c;
    t[1] = 2 * c;
    t[2] = 2 * c + 1;
    t[3] = (c + 1 < n) ? 2 * c + 2 : 2 * c + 1;
  endfunction

  function int tap_wt(int k);
    return (k == 1 || k == 2) ? 3 : 1;
  endfunction

  function bit write_in_range(grid_req_t r);
    return (r.x < 2 * eff_size(0)) && (r.y < 2 * eff_size(1)) && (r.z < 2 * eff_size(2));
  endfunction

  function bit cell_in_range(int cx, int cy, int cz);
    return (cx < eff_size(0)) && (cy < eff_size(1)) && (cz < eff_size(2));
  endfunction

  // True when every tap of the cell holds a written sample.
  function bit cell_filled(int cx, int cy, int cz);
    int tx[4], ty[4], tz[4];
    axis_taps(cx, eff_size(0), tx);
    axis_taps(cy, eff_size(1), ty);
    axis_taps(cz, eff_size(2), tz);
    foreach (tz[c])
      foreach (ty[b])
        foreach (tx[a])
          if (!written[fine_index(tx[a], ty[b], tz[c])]) return 1'b0;
    return 1'b1;
  endfunction

  // 1,3,3,1 separable weighting, exact sum, then /512 rounding half up.
  function logic signed [31:0] restrict_cell(int cx, int cy, int cz);
    int     tx[4], ty[4], tz[4];
    longint acc;
    axis_taps(cx, eff_size(0), tx);
    axis_taps(cy, eff_size(1), ty);
    axis_taps(cz, eff_size(2), tz);
    acc = 0;
    foreach (tz[c])
      foreach (ty[b])
        foreach (tx[a])
          acc += longint'(tap_wt(a) * tap_wt(b) * tap_wt(c)) *
                 longint'(fine_mem[fine_index(tx[a], ty[b], tz[c])]);
    acc = (acc + 64'sd256) >>> 9;
    return acc[31:0];
  endfunction

  function void note_request(grid_req_t r);
    coarse_res_t res;
    int          idx;
    if (r.op == g3d_rfw_pkg::OpWrite) begin
      if (write_in_range(r)) begin
        idx           = fine_index(r.x, r.y, r.z);
        fine_mem[idx] = r.sample;
        written[idx]  = 1'b1;
      end
    end else begin
      if (cell_in_range(r.x, r.y, r.z)) begin
        res.value = restrict_cell(r.x, r.y, r.z);
        res.err   = 1'b0;
      end else begin
        res.value = '0;
        res.err   = 1'b1;
      end
      coarse_q.push_back(res);
    end
  endfunction

  function void check_result(logic signed [31:0] value, logic err);
    coarse_res_t exp_res;
    checked++;
    if (coarse_q.size() == 0) begin
      if (mismatches < 10)
        $display("result %0d arrived with nothing pending: value %h err %b",
                 checked, value, err);
      mismatches++;
      return;
    end
    exp_res = coarse_q.pop_front();
    if (value !== exp_res.value || err !== exp_res.err) begin
      if (mismatches < 10)
        $display("result %0d wrong: expected value %h err %b, got value %h err %b",
                 checked, exp_res.value, exp_res.err, value, err);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  import g3d_rfw_pkg::*;

  // Hard stop on the cycle counter.
  localparam int unsigned CycleLimit   = 500000;
  // Long enough to cover a compute, with margin.
  localparam int unsigned SettleCycles = 80;
  // Length of the one long output stall that backs the block up.
  localparam int unsigned LongHold     = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  g3d_rfw_req_if #(.SAMPLE_WIDTH(32)) req_if ();
  g3d_rfw_rsp_if #(.SAMPLE_WIDTH(32)) rsp_if ();

  grid3d_restrict_full_weighting #(
    .COARSE_MAX  (16),
    .SAMPLE_WIDTH(32)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  coarse_scoreboard sb;

  int unsigned cycle_cnt = 0;
  int          req_idle_pct;     // owned by the stimulus process
  int          rsp_idle_pct;     // written by NBA, read by the sink
  logic        hold_req = 1'b0;  // asks the sink for its one long stall
  int          phase_items;      // requests that do something (ignored writes excluded)
  int          phase_results;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result sink: checks every accepted result and drives ready. Ready is
  // dropped at random per the current idle rate, and once for a long
  // stretch when the stimulus asks for it, so the block fills up and has
  // to stall its request channel.
  // ---------------------------------------------------------------------
  initial begin : rsp_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        sb.check_result(rsp_if.coarse_value, rsp_if.range_error);
      if (hold_req && !hold_done) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver tasks. Each one is entered and left just after a rising edge.
  // ---------------------------------------------------------------------

  // Offers one request, with random gaps ahead of it, and books it in the
  // scoreboard at the edge that accepts it.
  task automatic send_req(input grid_req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= r.op;
    req_if.pos_x        <= r.x;
    req_if.pos_y        <= r.y;
    req_if.pos_z        <= r.z;
    req_if.sample_value <= r.sample;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    if (r.op == OpCompute) begin
      phase_items++;
      phase_results++;
    end else if (sb.write_in_range(r)) begin
      phase_items++;
    end
    sb.note_request(r);
  endtask

  task automatic send_write(input int x, input int y, input int z,
                            input logic signed [31:0] value);
    grid_req_t r;
    r.op     = OpWrite;
    r.x      = PosW'(x);
    r.y      = PosW'(y);
    r.z      = PosW'(z);
    r.sample = value;
    send_req(r);
  endtask

  // The sample field is don't-care on a compute, so it carries noise.
  task automatic send_compute(input int x, input int y, input int z);
    grid_req_t r;
    r.op     = OpCompute;
    r.x      = PosW'(x);
    r.y      = PosW'(y);
    r.z      = PosW'(z);
    r.sample = $urandom;
    send_req(r);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [1:0] reg_idx, input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.size_reg[reg_idx] = value;
  endtask

  // Stop offering, wait for every pending result, then let in-flight
  // writes and any trailing work settle before touching registers.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.coarse_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic start_phase(input logic [4:0] sx, input logic [4:0] sy,
                             input logic [4:0] sz);
    wait_idle();
    cfg_write(RegSizeX, sx);
    cfg_write(RegSizeY, sy);
    cfg_write(RegSizeZ, sz);
    phase_items   = 0;
    phase_results = 0;
  endtask

  // Mostly plain 32-bit noise, with the extremes and small values mixed in.
  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'($signed($urandom_range(511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  // On large axes stay near one of the ends so neighboring cells share
  // taps and the fills stay cheap; small axes are covered in full.
  function automatic int pick_coord(input int n);
    if (n > 4 && $urandom_range(3) != 0) begin
      if ($urandom_range(1) != 0) return $urandom_range(2);
      return n - 1 - $urandom_range(2);
    end
    return $urandom_range(n - 1);
  endfunction

  // Well-formed sequence: fill whatever taps of one coarse cell are still
  // empty (and refresh a few at random), then ask for the cell. Now and
  // then the sequence is cut short before the compute.
  task automatic restrict_sequence(input int nx, input int ny, input int nz);
    int cx, cy, cz;
    int tx[4], ty[4], tz[4];
    cx = pick_coord(nx);
    cy = pick_coord(ny);
    cz = pick_coord(nz);
    sb.axis_taps(cx, nx, tx);
    sb.axis_taps(cy, ny, ty);
    sb.axis_taps(cz, nz, tz);
    foreach (tz[c])
      foreach (ty[b])
        foreach (tx[a])
          if (!sb.written[sb.fine_index(tx[a], ty[b], tz[c])] || $urandom_range(15) == 0)
            send_write(tx[a], ty[b], tz[c], rand_sample());
    if ($urandom_range(9) != 0)
      send_compute(cx, cy, cz);
  endtask

  // Write past the configured fine size on at least one axis; dropped.
  task automatic stray_write(input int nx, input int ny, input int nz);
    int lim[3];
    int pos[3];
    int axis;
    lim = '{2 * nx, 2 * ny, 2 * nz};
    if (lim[0] >= 32 && lim[1] >= 32 && lim[2] >= 32) return;
    do axis = $urandom_range(2); while (lim[axis] >= 32);
    foreach (pos[k]) pos[k] = $urandom_range(31);
    pos[axis] = $urandom_range(31, lim[axis]);
    send_write(pos[0], pos[1], pos[2], rand_sample());
  endtask

  // Compute on a coarse cell past the configured size; flags an error.
  task automatic stray_compute(input int nx, input int ny, input int nz);
    int lim[3];
    int pos[3];
    int axis;
    lim  = '{nx, ny, nz};
    axis = $urandom_range(2);
    foreach (pos[k]) pos[k] = $urandom_range(31);
    pos[axis] = $urandom_range(31, lim[axis]);
    send_compute(pos[0], pos[1], pos[2]);
  endtask

  task automatic random_step();
    int nx, ny, nz;
    int sel;
    int cx, cy, cz;
    nx  = sb.eff_size(0);
    ny  = sb.eff_size(1);
    nz  = sb.eff_size(2);
    sel = $urandom_range(99);
    if (sel < 70) begin
      restrict_sequence(nx, ny, nz);
    end else if (sel < 80) begin
      send_write($urandom_range(2 * nx - 1), $urandom_range(2 * ny - 1),
                 $urandom_range(2 * nz - 1), rand_sample());
    end else if (sel < 88) begin
      stray_write(nx, ny, nz);
    end else if (sel < 95) begin
      stray_compute(nx, ny, nz);
    end else begin
      // Any in-range cell, but only if all of its taps hold data.
      cx = $urandom_range(nx - 1);
      cy = $urandom_range(ny - 1);
      cz = $urandom_range(nz - 1);
      if (sb.cell_filled(cx, cy, cz)) send_compute(cx, cy, cz);
    end
  endtask

  task automatic run_random(input int quota, input int min_results);
    while (phase_items < quota || phase_results < min_results) random_step();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    sb                  = new();
    req_if.valid        = 1'b0;
    req_if.opcode       = OpWrite;
    req_if.pos_x        = '0;
    req_if.pos_y        = '0;
    req_if.pos_z        = '0;
    req_if.sample_value = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    phase_items         = 0;
    phase_results       = 0;

    // Sender sparse-ish, receiver mostly stalled.
    req_idle_pct = 35;
    rsp_idle_pct = 82;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the smallest grid (2x2x2 fine): the outer taps clamp and
    // the result is the plain mean of the eight samples.
    start_phase(5'd1, 5'd1, 5'd1);
    for (int k = 0; k < 8; k++) send_write(k & 1, (k >> 1) & 1, k >> 2, 32'sh7FFF_FFFF);
    send_compute(0, 0, 0);                       // largest positive mean
    for (int k = 0; k < 8; k++) send_write(k & 1, (k >> 1) & 1, k >> 2, 32'sh8000_0000);
    send_compute(0, 0, 0);                       // most negative mean
    send_write(0, 0, 0, 32'sh8000_0004);         // mean lands on an exact half
    send_compute(0, 0, 0);                       // ... rounds toward +inf
    send_compute(1, 0, 0);                       // coarse cell past the size
    send_compute(31, 31, 31);
    send_write(2, 0, 0, 32'sh1234_5678);         // fine writes past the size
    send_write(31, 31, 31, 32'sh0BAD_CAFE);      // are dropped
    send_compute(0, 0, 0);                       // grid unchanged

    start_phase(5'd2, 5'd2, 5'd2);
    run_random(90, 12);
    // Size registers out of range: 0 acts as 1, 31 as the maximum.
    start_phase(5'd0, 5'd3, 5'd31);
    run_random(90, 10);

    // Swap: sender mostly idle, receiver mostly ready.
    wait_idle();
    req_idle_pct = 82;
    rsp_idle_pct <= 35;
    start_phase(5'd16, 5'd16, 5'd16);
    run_random(90, 6);
    start_phase(5'd4, 5'd2, 5'd1);
    run_random(90, 10);

    // Full rate both ways, with one long output stall to back things up.
    wait_idle();
    req_idle_pct = 0;
    rsp_idle_pct <= 0;
    start_phase(5'd3, 5'd1, 5'd5);
    hold_req <= 1'b1;
    run_random(100, 12);
    start_phase(5'd16, 5'd1, 5'd2);
    run_random(90, 10);

    wait_idle();
    if (sb.mismatches == 0 && sb.coarse_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/g3d_rfw_pkg.sv
design/g3d_rfw_if.sv
design/g3d_rfw_cfg.sv
design/g3d_rfw_mem.sv
design/g3d_rfw_mac.sv
design/g3d_rfw_seq.sv
design/grid3d_restrict_full_weighting.sv
test/testbench.sv
